// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hmar_pkg.sv -----
// ----------------------------------------------------------------------------
// hmar_pkg
// types, constants and helpers of the host message ack responder
// ----------------------------------------------------------------------------
package hmar_pkg;

    // response ring, a power of two so ring arithmetic wraps naturally
    localparam int SLOT_W     = 9;
    localparam int RING_WORDS = 1 << SLOT_W;
    localparam int NEED_FREE  = 3;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [31:0]       t_word;

    // ack header fields
    localparam logic [7:0] ACK_ID   = 8'd126;
    localparam logic [7:0] ACK_SIZE = 8'd3;

    // message ids that get an acknowledgement
    localparam logic [7:0] MSG_ID_0  = 8'd0;
    localparam logic [7:0] MSG_ID_1  = 8'd1;
    localparam logic [7:0] MSG_ID_3  = 8'd3;
    localparam logic [7:0] MSG_ID_4  = 8'd4;
    localparam logic [7:0] MSG_ID_5  = 8'd5;
    localparam logic [7:0] MSG_ID_10 = 8'd10;
    localparam logic [7:0] MSG_ID_14 = 8'd14;

    // load request from the decoder into the emitter
    typedef struct packed {
        logic  load;
        t_word hdr;
        t_slot slot;
    } t_emit_cmd;

    // emitter status back to the decoder
    typedef struct packed {
        logic free;
    } t_emit_stat;

    function automatic logic id_known(input logic [7:0] id);
        logic known;
        case (id) inside
            MSG_ID_0, MSG_ID_1, MSG_ID_3, MSG_ID_4,
            MSG_ID_5, MSG_ID_10, MSG_ID_14: known = 1'b1;
            default:                        known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

// ----- rtl/core/hmar_if.sv -----
// ----------------------------------------------------------------------------
// hmar_if
// valid/ready channels for queue words in and ring words out
// ----------------------------------------------------------------------------
interface hmar_in_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          host_word;
    logic [8:0]           resp_read_pos;

    modport source (output valid, output host_word, output resp_read_pos, input ready);
    modport sink   (input valid, input host_word, input resp_read_pos, output ready);
endinterface

interface hmar_out_if;
    logic                 valid;
    logic                 ready;
    logic [31:0]          resp_word;
    logic [8:0]           resp_slot;
    logic [8:0]           resp_write_pos;
    logic                 last_word;

    modport source (output valid, output resp_word, output resp_slot,
                    output resp_write_pos, output last_word, input ready);
    modport sink   (input valid, input resp_word, input resp_slot,
                    input resp_write_pos, input last_word, output ready);
endinterface

// ----- rtl/core/hmar_emit.sv -----
// ----------------------------------------------------------------------------
// hmar_emit
// result register that plays out one three-word acknowledgement
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hmar_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hmar_pkg::t_emit_cmd i_cmd,
    output hmar_pkg::t_emit_stat o_stat,
    hmar_out_if.source          o_out
);
    import hmar_pkg::*;

    // words still to send; value names the word on the port
    localparam logic [1:0] CNT_IDLE    = 2'd0;
    localparam logic [1:0] CNT_ERR     = 2'd1;
    localparam logic [1:0] CNT_ORIG    = 2'd2;
    localparam logic [1:0] CNT_ACK_HDR = 2'd3;

    logic [1:0] r_cnt, n_cnt;
    t_word      r_hdr;
    t_slot      r_slot, n_slot;
    logic       w_take;

    assign w_take      = o_out.valid && o_out.ready;
    assign o_stat.free = (r_cnt == CNT_IDLE) || ((r_cnt == CNT_ERR) && o_out.ready);

    always_comb begin
        n_cnt  = r_cnt;
        n_slot = r_slot;
        if (i_cmd.load) begin
            n_cnt  = CNT_ACK_HDR;
            n_slot = i_cmd.slot;
        end else if (w_take) begin
            n_cnt  = r_cnt - 2'd1;
            n_slot = r_slot + t_slot'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_IDLE;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot <= n_slot;
        if (i_cmd.load) begin
            r_hdr <= i_cmd.hdr;
        end
    end

    always_comb begin
        case (r_cnt)
            CNT_ACK_HDR: o_out.resp_word = {r_hdr[31:20], 4'h0, ACK_SIZE, ACK_ID};
            CNT_ORIG:    o_out.resp_word = r_hdr;
            default:     o_out.resp_word = '0;
        endcase
    end

    assign o_out.valid          = (r_cnt != CNT_IDLE);
    assign o_out.resp_slot      = r_slot;
    assign o_out.resp_write_pos = r_slot + t_slot'(1);
    assign o_out.last_word      = (r_cnt == CNT_ERR);

    `ASSERT_CLK(a_load_when_free, !i_cmd.load || o_stat.free, "emitter loaded while busy")
    `ASSERT_NEXT(a_load_starts, i_cmd.load, o_out.valid && !o_out.last_word, "ack did not start")
    `ASSERT_NEXT(a_slot_steps, w_take && !o_out.last_word,
        o_out.valid && (o_out.resp_slot == $past(o_out.resp_write_pos)), "slot skipped")
endmodule

// ----- rtl/core/host_message_ack_responder_unit.sv -----
// an ack header is held in the input register until the emitter is free and loads it
// one queue word per cycle unless an ack waits on a busy emitter; an ack holds the emitter
//   until its three ring words are taken; the result channel carries one word per cycle
// payload words, unknown ids and dropped acks never wait for the emitter and emit nothing
// reset (synchronous, active low): ring write index and payload skip count go to zero,
//   input and result registers empty
// ----------------------------------------------------------------------------
// host_message_ack_responder_unit
// decodes host queue headers, skips payload, writes three-word acks to a ring
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module host_message_ack_responder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hmar_in_if.sink    i_in,
    hmar_out_if.source o_out
);
    import hmar_pkg::*;

    // input register
    logic       r_in_valid;
    t_word      r_in_word;
    t_slot      r_in_rd;

    // block state: ring write index and payload words still to skip
    t_slot      r_wr_idx, n_wr_idx;
    logic [7:0] r_skip, n_skip;

    // header decode
    logic [7:0] w_id;
    logic [7:0] w_size;
    t_slot      w_used;
    logic       w_room;
    logic       w_is_hdr;
    logic       w_want_emit;
    logic       w_consume;

    t_emit_cmd  w_cmd;
    t_emit_stat w_stat;

    assign w_id     = r_in_word[7:0];
    assign w_size   = r_in_word[15:8];
    assign w_is_hdr = (r_skip == 8'd0);

    // occupied slots between host read index and our write index, mod ring size
    assign w_used = r_wr_idx - r_in_rd;
    // at least three free slots
    assign w_room = (w_used <= t_slot'(RING_WORDS - NEED_FREE));

    assign w_want_emit = w_is_hdr && id_known(w_id) && w_room;

    // an item that emits nothing retires at once; an ack waits for the emitter
    assign w_consume = r_in_valid && (!w_want_emit || w_stat.free);
    assign i_in.ready = !r_in_valid || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.host_word;
            r_in_rd   <= i_in.resp_read_pos;
        end
    end

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_skip   = r_skip;
        if (w_consume) begin
            if (!w_is_hdr) begin
                // payload word, skipped whatever it holds
                n_skip = r_skip - 8'd1;
            end else begin
                // a size of zero counts as one, so no payload follows
                n_skip = (w_size == 8'd0) ? 8'd0 : w_size - 8'd1;
                if (w_want_emit) begin
                    n_wr_idx = r_wr_idx + t_slot'(NEED_FREE);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_skip   <= 8'd0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_skip   <= n_skip;
        end
    end

    // hand the header and its first ring slot to the emitter
    assign w_cmd.load = w_consume && w_want_emit;
    assign w_cmd.hdr  = r_in_word;
    assign w_cmd.slot = r_wr_idx;

    hmar_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

    `ASSERT_CLK(a_payload_silent, !(w_cmd.load && (r_skip != 8'd0)), "ack raised on payload")
    `ASSERT_NEXT(a_wr_idx_step, w_cmd.load, r_wr_idx == t_slot'($past(r_wr_idx) + t_slot'(3)),
        "write index not advanced by an ack")
    `ASSERT_CLK(a_empty_ready, r_in_valid || i_in.ready, "input stalled while empty")
endmodule
